// ===== rtl/reverse_charge_mode_controller_unit_defines.svh =====
// assertion macros for the reverse-charge mode controller
// used by the top level only, needs clk and rst_n in scope
`ifndef REVERSE_CHARGE_MODE_CONTROLLER_UNIT_DEFINES_SVH
`define REVERSE_CHARGE_MODE_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define RCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcm assertion failed");

// next-cycle implication
`define RCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcm assertion failed");

`endif

// ===== rtl/rcm_pkg.sv =====
// shared types and constants of the reverse-charge mode controller
// no dependencies
package rcm_pkg;

  localparam int TABLE_ROWS = 6;
  localparam int ROW_SLOTS  = 6;

  localparam logic [15:0] DEF_MV = 16'd5000;
  localparam logic [15:0] DEF_MA = 16'd1500;
  localparam logic signed [7:0] TEMP_LIMIT_RST = 8'sd45;

  typedef enum logic [2:0] {
    ACT_OTG_ON   = 3'd0,
    ACT_OTG_OFF  = 3'd1,
    ACT_HV_ON    = 3'd2,
    ACT_HV_OFF   = 3'd3,
    ACT_WLS_ON   = 3'd4,
    ACT_WLS_OFF  = 3'd5,
    ACT_OTG_TMR  = 3'd6,
    ACT_MON_TMR  = 3'd7
  } action_t;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_HV     = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_IC_FAIL = 2'd2;

  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_ENABLE  = 2'd1;
  localparam logic [1:0] CMD_DISABLE = 2'd2;

  localparam logic [2:0] REG_TEMP_LIMIT = 3'd0;

  // packed as the register: ma in 38:23, mv in 22:7, threshold in 6:0
  typedef struct packed {
    logic [15:0] ma;
    logic [15:0] mv;
    logic [6:0]  thr;
  } row_t;

  typedef struct packed {
    logic        dflt;
    logic        hit;
    logic [15:0] mv;
    logic [15:0] ma;
  } cap_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  ic_command;
    logic        notify_valid;
    logic [15:0] notify_mv;
    logic [15:0] notify_ma;
    logic [1:0]  mode_now;
    logic        otg_timer_on;
    logic        monitor_timer_on;
  } result_t;

endpackage

// ===== rtl/rcm_cfg_regs.sv =====
// configuration registers: temperature limit and capability table
// depends on rcm_pkg
module rcm_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [2:0]                  wr_index,
  input  logic [38:0]                 wr_data,
  output logic signed [7:0]           temp_limit,
  output rcm_pkg::row_t               rows [rcm_pkg::ROW_SLOTS]
);
  import rcm_pkg::*;

  logic signed [7:0] temp_limit_r;
  row_t              rows_r [ROW_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_limit_r <= TEMP_LIMIT_RST;
      for (int i = 0; i < ROW_SLOTS; i++) begin
        rows_r[i] <= '0;
      end
    end else if (wr_en) begin
      if (wr_index == REG_TEMP_LIMIT) begin
        temp_limit_r <= signed'(wr_data[7:0]);
      end
      for (int i = 0; i < ROW_SLOTS; i++) begin
        if (wr_index == 3'(i + 1)) begin
          rows_r[i] <= row_t'(wr_data);
        end
      end
    end
  end

  assign temp_limit = temp_limit_r;
  assign rows       = rows_r;

endmodule

// ===== rtl/rcm_cap_sel.sv =====
// capability pick: default on busy or hot battery, else first matching row
// depends on rcm_pkg
module rcm_cap_sel (
  input  logic                  wls_plugged,
  input  logic                  tx_busy,
  input  logic [6:0]            charge_level,
  input  logic signed [7:0]     battery_temp,
  input  logic signed [7:0]     temp_limit,
  input  rcm_pkg::row_t         rows [rcm_pkg::ROW_SLOTS],
  output rcm_pkg::cap_t         cap
);
  import rcm_pkg::*;

  always_comb begin
    cap      = '0;
    cap.dflt = wls_plugged | tx_busy | (battery_temp > temp_limit);
    // walk from the last row down so the lowest matching row wins
    for (int i = TABLE_ROWS - 1; i >= 0; i--) begin
      if (charge_level >= rows[i].thr) begin
        cap.hit = 1'b1;
        cap.mv  = rows[i].mv;
        cap.ma  = rows[i].ma;
      end
    end
  end

endmodule

// ===== rtl/rcm_core.sv =====
// mode state and per-request step logic
// depends on rcm_pkg and rcm_cap_sel
module rcm_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [2:0]            action,
  input  logic [6:0]            charge_level,
  input  logic signed [7:0]     battery_temp,
  input  logic                  tx_busy,
  input  logic                  ic_ack,
  input  logic signed [7:0]     temp_limit,
  input  rcm_pkg::row_t         rows [rcm_pkg::ROW_SLOTS],
  output rcm_pkg::result_t      res
);
  import rcm_pkg::*;

  logic [1:0]  mode_r, mode_nxt;
  logic        wls_r, wls_nxt;
  logic [15:0] last_mv_r, last_mv_nxt;
  logic [15:0] last_ma_r, last_ma_nxt;
  logic        otg_r, otg_nxt;
  logic        mon_r, mon_nxt;
  cap_t        cap;
  action_t     act;
  logic [15:0] cand_mv, cand_ma;

  rcm_cap_sel u_cap_sel (
    .wls_plugged  (wls_r),
    .tx_busy      (tx_busy),
    .charge_level (charge_level),
    .battery_temp (battery_temp),
    .temp_limit   (temp_limit),
    .rows         (rows),
    .cap          (cap)
  );

  assign act = action_t'(action);

  always_comb begin
    mode_nxt    = mode_r;
    wls_nxt     = wls_r;
    last_mv_nxt = last_mv_r;
    last_ma_nxt = last_ma_r;
    otg_nxt     = otg_r;
    mon_nxt     = mon_r;
    res         = '0;
    res.status     = ST_OK;
    res.ic_command = CMD_NONE;
    cand_mv     = DEF_MV;
    cand_ma     = DEF_MA;
    case (act)
      ACT_OTG_ON: begin
        if (mode_r != MODE_NORMAL) begin
          mode_nxt = MODE_NORMAL;
          otg_nxt  = 1'b1;
        end
      end
      ACT_OTG_OFF: begin
        otg_nxt = 1'b0;
        if (mode_r == MODE_HV) begin
          res.ic_command = CMD_DISABLE;
          res.status     = ic_ack ? ST_OK : ST_IC_FAIL;
          mon_nxt        = 1'b0;
        end
        mode_nxt = MODE_IDLE;
      end
      ACT_HV_ON: begin
        if (mode_r != MODE_HV) begin
          if (wls_r || tx_busy) begin
            res.status = ST_BUSY;
          end else begin
            res.ic_command = CMD_ENABLE;
            if (ic_ack) begin
              mode_nxt = MODE_HV;
              mon_nxt  = 1'b1;
            end else begin
              res.status = ST_IC_FAIL;
            end
          end
        end
      end
      ACT_HV_OFF: begin
        res.ic_command = CMD_DISABLE;
        res.status     = ic_ack ? ST_OK : ST_IC_FAIL;
        mode_nxt       = MODE_NORMAL;
        mon_nxt        = 1'b0;
      end
      ACT_WLS_ON: begin
        wls_nxt = 1'b1;
        if (mode_r == MODE_HV) begin
          res.ic_command   = CMD_DISABLE;
          res.status       = ic_ack ? ST_OK : ST_IC_FAIL;
          mode_nxt         = MODE_NORMAL;
          mon_nxt          = 1'b0;
          // default advertised, stored capability left alone
          res.notify_valid = 1'b1;
          res.notify_mv    = DEF_MV;
          res.notify_ma    = DEF_MA;
        end
      end
      ACT_WLS_OFF: begin
        wls_nxt = 1'b0;
      end
      ACT_OTG_TMR: begin
        if (otg_r) begin
          otg_nxt = 1'b0;
          if (!cap.dflt && cap.hit) begin
            cand_mv = cap.mv;
            cand_ma = cap.ma;
          end
          if (cand_mv != DEF_MV) begin
            last_mv_nxt      = cand_mv;
            last_ma_nxt      = cand_ma;
            res.notify_valid = 1'b1;
            res.notify_mv    = cand_mv;
            res.notify_ma    = cand_ma;
          end
        end
      end
      ACT_MON_TMR: begin
        if (mon_r) begin
          if (mode_r != MODE_HV) begin
            mon_nxt = 1'b0;
          end else begin
            // no matching row gives zero here, not the default
            if (cap.dflt) begin
              cand_mv = DEF_MV;
              cand_ma = DEF_MA;
            end else if (cap.hit) begin
              cand_mv = cap.mv;
              cand_ma = cap.ma;
            end else begin
              cand_mv = '0;
              cand_ma = '0;
            end
            if (cand_mv != last_mv_r || cand_ma != last_ma_r) begin
              last_mv_nxt      = cand_mv;
              last_ma_nxt      = cand_ma;
              res.notify_valid = 1'b1;
              res.notify_mv    = cand_mv;
              res.notify_ma    = cand_ma;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.mode_now         = mode_nxt;
    res.otg_timer_on     = otg_nxt;
    res.monitor_timer_on = mon_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      wls_r     <= 1'b0;
      last_mv_r <= '0;
      last_ma_r <= '0;
      otg_r     <= 1'b0;
      mon_r     <= 1'b0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      wls_r     <= wls_nxt;
      last_mv_r <= last_mv_nxt;
      last_ma_r <= last_ma_nxt;
      otg_r     <= otg_nxt;
      mon_r     <= mon_nxt;
    end
  end

endmodule

// ===== rtl/reverse_charge_mode_controller_unit.sv =====
// Reverse-charge mode controller, top level.
// Channels: in_* carries one request (action plus battery readings and IC ack),
// out_* returns exactly one result per request, cfg_* writes the temperature
// limit (index 0) and table rows 0..5 (indices 1..6); other indices are dropped.
// cfg_ready is always high; write configuration only while no request is in flight.
// A request accepted on in_* is presented on out_* from the result register
// (input register, then step logic into the result register).
// Throughput: one request per cycle while out_ready stays high; the combinational
// step logic and its state update in the core set this rate.
// in_ready stays high while the input register is empty or the result register is
// empty or being drained, so a new request is taken while a finished result waits.
// When the receiver stalls, the result holds, then the input register fills, then in_ready drops.
// Reset (rst_n low, synchronous): mode idle, timers disarmed, wireless flag and
// stored capability cleared, temperature limit 45, table rows zero, no result.
// Depends on rcm_pkg, rcm_cfg_regs, rcm_core, rcm_cap_sel and the defines header.
`include "reverse_charge_mode_controller_unit_defines.svh"

module reverse_charge_mode_controller_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_action,
  input  logic [6:0]        in_charge_level,
  input  logic signed [7:0] in_battery_temp,
  input  logic              in_tx_busy,
  input  logic              in_ic_ack,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [1:0]        out_ic_command,
  output logic              out_notify_valid,
  output logic [15:0]       out_notify_mv,
  output logic [15:0]       out_notify_ma,
  output logic [1:0]        out_mode_now,
  output logic              out_otg_timer_on,
  output logic              out_monitor_timer_on,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [38:0]       cfg_data
);
  import rcm_pkg::*;

  logic              s1_vld_r;
  logic [2:0]        s1_action_r;
  logic [6:0]        s1_soc_r;
  logic signed [7:0] s1_temp_r;
  logic              s1_busy_r;
  logic              s1_ack_r;
  logic              out_vld_r;
  result_t           out_res_r;
  result_t           step_res;
  logic              out_free;
  logic              s1_adv;
  logic              in_take;
  logic signed [7:0] temp_limit;
  row_t              rows [ROW_SLOTS];

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || out_ready;
  assign s1_adv    = s1_vld_r && out_free;
  assign in_ready  = !s1_vld_r || out_free;
  assign in_take   = in_valid && in_ready;

  rcm_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cfg_valid && cfg_ready),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .temp_limit (temp_limit),
    .rows       (rows)
  );

  rcm_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_adv),
    .action       (s1_action_r),
    .charge_level (s1_soc_r),
    .battery_temp (s1_temp_r),
    .tx_busy      (s1_busy_r),
    .ic_ack       (s1_ack_r),
    .temp_limit   (temp_limit),
    .rows         (rows),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_soc_r    <= in_charge_level;
      s1_temp_r   <= in_battery_temp;
      s1_busy_r   <= in_tx_busy;
      s1_ack_r    <= in_ic_ack;
    end
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_status           = out_res_r.status;
  assign out_ic_command       = out_res_r.ic_command;
  assign out_notify_valid     = out_res_r.notify_valid;
  assign out_notify_mv        = out_res_r.notify_mv;
  assign out_notify_ma        = out_res_r.notify_ma;
  assign out_mode_now         = out_res_r.mode_now;
  assign out_otg_timer_on     = out_res_r.otg_timer_on;
  assign out_monitor_timer_on = out_res_r.monitor_timer_on;

  `RCM_ASSERT_IMP(a_quiet_notify, out_vld_r && !out_res_r.notify_valid,
    out_res_r.notify_mv == 16'd0 && out_res_r.notify_ma == 16'd0)
  `RCM_ASSERT_IMP(a_fail_has_cmd, out_vld_r && out_res_r.status == ST_IC_FAIL,
    out_res_r.ic_command != CMD_NONE)
  `RCM_ASSERT_IMP(a_busy_no_cmd, out_vld_r && out_res_r.status == ST_BUSY,
    out_res_r.ic_command == CMD_NONE)
  `RCM_ASSERT_NXT(a_stage_fills, s1_vld_r && !out_free, s1_vld_r && out_vld_r)

endmodule

// ===== test/testbench.sv =====
// testbench for the reverse-charge mode controller: directed action sequences, then
// random charge sessions checked against a behavioral predictor of mode, timers and
// advertised capability. depends on rcm_pkg and reverse_charge_mode_controller_unit
`timescale 1ns / 100ps

module testbench;
  import rcm_pkg::*;

  localparam logic [2:0] REG_ROW_BASE = 3'd1;
  localparam logic [2:0] REG_SPARE    = 3'd7;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         ITEM_TARGET  = 1250;
  localparam int         TAIL_ITEMS   = 150;

  typedef struct {
    action_t            act;
    logic [6:0]         soc;
    logic signed [7:0]  temp;
    logic               busy;
    logic               ack;
  } request_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_action = '0;
  logic [6:0]        in_charge_level = '0;
  logic signed [7:0] in_battery_temp = '0;
  logic              in_tx_busy = 1'b0;
  logic              in_ic_ack = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [1:0]        out_ic_command;
  logic              out_notify_valid;
  logic [15:0]       out_notify_mv;
  logic [15:0]       out_notify_ma;
  logic [1:0]        out_mode_now;
  logic              out_otg_timer_on;
  logic              out_monitor_timer_on;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [38:0]       cfg_data = '0;

  // predictor state and its copy of the registers
  logic [1:0]        ctl_mode;
  logic              wls_on;
  logic [15:0]       adv_mv;
  logic [15:0]       adv_ma;
  logic              otg_tmr;
  logic              mon_tmr;
  logic signed [7:0] lim_temp;
  row_t              cap_rows [TABLE_ROWS];

  result_t     pending_results [$];
  int          items_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int unsigned hold_cnt = 0;
  bit          idle_on = 1'b0;

  reverse_charge_mode_controller_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_charge_level      (in_charge_level),
    .in_battery_temp      (in_battery_temp),
    .in_tx_busy           (in_tx_busy),
    .in_ic_ack            (in_ic_ack),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_ic_command       (out_ic_command),
    .out_notify_valid     (out_notify_valid),
    .out_notify_mv        (out_notify_mv),
    .out_notify_ma        (out_notify_ma),
    .out_mode_now         (out_mode_now),
    .out_otg_timer_on     (out_otg_timer_on),
    .out_monitor_timer_on (out_monitor_timer_on),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void reset_controller_model();
    ctl_mode = MODE_IDLE;
    wls_on   = 1'b0;
    adv_mv   = '0;
    adv_ma   = '0;
    otg_tmr  = 1'b0;
    mon_tmr  = 1'b0;
    lim_temp = TEMP_LIMIT_RST;
    for (int i = 0; i < TABLE_ROWS; i++) cap_rows[i] = '0;
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [38:0] data);
    if (idx == REG_TEMP_LIMIT)
      lim_temp = data[7:0];
    else if (int'(idx) >= int'(REG_ROW_BASE) && int'(idx) < int'(REG_ROW_BASE) + TABLE_ROWS)
      cap_rows[int'(idx) - int'(REG_ROW_BASE)] = data;
  endfunction

  // default capability when wireless is busy or too hot, else first row the charge meets
  function automatic void choose_capability(input request_t r, inout logic [15:0] mv,
                                            inout logic [15:0] ma);
    bit found;
    found = 1'b0;
    if (wls_on || r.busy || r.temp > lim_temp) begin
      mv = DEF_MV;
      ma = DEF_MA;
    end else begin
      for (int i = 0; i < TABLE_ROWS; i++) begin
        if (!found && r.soc >= cap_rows[i].thr) begin
          mv = cap_rows[i].mv;
          ma = cap_rows[i].ma;
          found = 1'b1;
        end
      end
    end
  endfunction

  function automatic void leave_high_voltage(input logic ack, inout result_t res);
    res.ic_command = CMD_DISABLE;
    res.status     = ack ? ST_OK : ST_IC_FAIL;
    ctl_mode       = MODE_NORMAL;
    mon_tmr        = 1'b0;
  endfunction

  function automatic result_t predict_controller(input request_t r);
    result_t     res;
    logic [15:0] mv;
    logic [15:0] ma;
    res = '0;
    res.status = ST_OK;
    res.ic_command = CMD_NONE;
    case (r.act)
      ACT_OTG_ON: begin
        if (ctl_mode != MODE_NORMAL) begin
          ctl_mode = MODE_NORMAL;
          otg_tmr  = 1'b1;
        end
      end
      ACT_OTG_OFF: begin
        otg_tmr = 1'b0;
        if (ctl_mode == MODE_HV) leave_high_voltage(r.ack, res);
        ctl_mode = MODE_IDLE;
      end
      ACT_HV_ON: begin
        if (ctl_mode != MODE_HV) begin
          if (wls_on || r.busy) begin
            res.status = ST_BUSY;
          end else begin
            res.ic_command = CMD_ENABLE;
            if (r.ack) begin
              ctl_mode = MODE_HV;
              mon_tmr  = 1'b1;
            end else begin
              res.status = ST_IC_FAIL;
            end
          end
        end
      end
      ACT_HV_OFF: leave_high_voltage(r.ack, res);
      ACT_WLS_ON: begin
        wls_on = 1'b1;
        // forced back to 5 V, stored capability left alone
        if (ctl_mode == MODE_HV) begin
          leave_high_voltage(r.ack, res);
          res.notify_valid = 1'b1;
          res.notify_mv    = DEF_MV;
          res.notify_ma    = DEF_MA;
        end
      end
      ACT_WLS_OFF: wls_on = 1'b0;
      ACT_OTG_TMR: begin
        if (otg_tmr) begin
          otg_tmr = 1'b0;
          mv = DEF_MV;
          ma = DEF_MA;
          choose_capability(r, mv, ma);
          if (mv != DEF_MV) begin
            adv_mv = mv;
            adv_ma = ma;
            res.notify_valid = 1'b1;
            res.notify_mv    = mv;
            res.notify_ma    = ma;
          end
        end
      end
      ACT_MON_TMR: begin
        if (mon_tmr) begin
          if (ctl_mode != MODE_HV) begin
            mon_tmr = 1'b0;
          end else begin
            mv = '0;
            ma = '0;
            choose_capability(r, mv, ma);
            if (mv != adv_mv || ma != adv_ma) begin
              adv_mv = mv;
              adv_ma = ma;
              res.notify_valid = 1'b1;
              res.notify_mv    = mv;
              res.notify_ma    = ma;
            end
          end
        end
      end
      default: ;
    endcase
    res.mode_now         = ctl_mode;
    res.otg_timer_on     = otg_tmr;
    res.monitor_timer_on = mon_tmr;
    return res;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic request_t make_request(input action_t a, input int soc, input int temp,
                                            input bit busy, input bit ack);
    request_t r;
    r.act  = a;
    r.soc  = 7'(soc);
    r.temp = 8'(temp);
    r.busy = busy;
    r.ack  = ack;
    return r;
  endfunction

  function automatic request_t random_request(input action_t a);
    request_t r;
    r.act  = a;
    r.soc  = 7'($urandom_range(0, 100));
    if ($urandom_range(0, 1) == 0)
      r.temp = 8'($urandom_range(0, 255));
    else
      r.temp = 8'(int'($urandom_range(0, 80)) - 20);
    r.busy = ($urandom_range(0, 7) == 0);
    r.ack  = ($urandom_range(0, 5) != 0);
    return r;
  endfunction

  // valid stays high after acceptance unless a gap follows; callers that stop
  // sending go through wait_all_results, which lowers it
  task automatic send_request(input request_t r);
    in_valid        <= 1'b1;
    in_action       <= r.act;
    in_charge_level <= r.soc;
    in_battery_temp <= r.temp;
    in_tx_busy      <= r.busy;
    in_ic_ack       <= r.ack;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_controller(r));
    items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [38:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
  endtask

  task automatic load_config(input logic signed [7:0] lim, input row_t rows_in [TABLE_ROWS]);
    wait_all_results();
    write_register(REG_TEMP_LIMIT, 39'(unsigned'(lim)));
    for (int i = 0; i < TABLE_ROWS; i++)
      write_register(REG_ROW_BASE + 3'(i), rows_in[i]);
    // unused index, must be dropped
    write_register(REG_SPARE, 39'({$urandom(), $urandom()}));
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_config(input int flavor);
    row_t              rows_new [TABLE_ROWS];
    logic signed [7:0] lim;
    int                thr;
    case (flavor)
      0: begin
        lim = 8'sd127;
        for (int i = 0; i < TABLE_ROWS; i++) rows_new[i] = '1;
      end
      1: begin
        lim = -8'sd128;
        for (int i = 0; i < TABLE_ROWS; i++) rows_new[i] = '0;
      end
      default: begin
        if ($urandom_range(0, 5) == 0)
          lim = 8'($urandom_range(0, 255));
        else
          lim = 8'($urandom_range(20, 60));
        thr = $urandom_range(60, 127);
        for (int i = 0; i < TABLE_ROWS; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            rows_new[i] = 39'({$urandom(), $urandom()});
          end else begin
            rows_new[i].thr = 7'(thr);
            case ($urandom_range(0, 7))
              0:       rows_new[i].mv = DEF_MV;
              1:       rows_new[i].mv = '1;
              2:       rows_new[i].mv = '0;
              default: rows_new[i].mv = 16'($urandom_range(5000, 20000));
            endcase
            rows_new[i].ma = 16'($urandom_range(0, 65535));
          end
          thr = thr - int'($urandom_range(0, 25));
          if (thr < 0) thr = 0;
        end
      end
    endcase
    load_config(lim, rows_new);
  endtask

  // ---------------------------------------------------------------- receiver and checker

  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= (hold_cnt == 1);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      hold_cnt  <= $urandom_range(1, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic string show_result(input result_t r);
    return $sformatf("status=%0d cmd=%0d notify=%0d mv=%0d ma=%0d mode=%0d otg=%0d mon=%0d",
                     r.status, r.ic_command, r.notify_valid, r.notify_mv, r.notify_ma,
                     r.mode_now, r.otg_timer_on, r.monitor_timer_on);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.status           = out_status;
      got.ic_command       = out_ic_command;
      got.notify_valid     = out_notify_valid;
      got.notify_mv        = out_notify_mv;
      got.notify_ma        = out_notify_ma;
      got.mode_now         = out_mode_now;
      got.otg_timer_on     = out_otg_timer_on;
      got.monitor_timer_on = out_monitor_timer_on;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: %s", results_seen, show_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.ic_command !== want.ic_command ||
            got.notify_valid !== want.notify_valid || got.notify_mv !== want.notify_mv ||
            got.notify_ma !== want.notify_ma || got.mode_now !== want.mode_now ||
            got.otg_timer_on !== want.otg_timer_on ||
            got.monitor_timer_on !== want.monitor_timer_on) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d", results_seen);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(got));
          end
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_mode_transitions();
    row_t rows_dir [TABLE_ROWS];
    rows_dir[0] = '{ma: 16'd2000, mv: 16'd9000,  thr: 7'd90};
    rows_dir[1] = '{ma: 16'd1000, mv: DEF_MV,    thr: 7'd70};
    rows_dir[2] = '{ma: 16'd1500, mv: 16'd7000,  thr: 7'd50};
    rows_dir[3] = '{ma: 16'd1200, mv: 16'd6000,  thr: 7'd30};
    rows_dir[4] = '{ma: 16'd1100, mv: 16'd5500,  thr: 7'd20};
    rows_dir[5] = '{ma: 16'd3000, mv: 16'd12000, thr: 7'd20};
    load_config(TEMP_LIMIT_RST, rows_dir);
    // timers fire while not armed
    send_request(make_request(ACT_OTG_TMR, 100, 0, 0, 1));
    send_request(make_request(ACT_MON_TMR, 100, 0, 0, 1));
    // hv off from idle still disables, ack missing
    send_request(make_request(ACT_HV_OFF, 0, 0, 0, 0));
    send_request(make_request(ACT_OTG_ON, 0, 0, 0, 1));
    send_request(make_request(ACT_OTG_OFF, 0, 0, 0, 1));
    send_request(make_request(ACT_OTG_ON, 0, 0, 0, 1));
    send_request(make_request(ACT_OTG_TMR, 100, -128, 0, 1));
    send_request(make_request(ACT_OTG_OFF, 0, 0, 0, 1));
    send_request(make_request(ACT_OTG_ON, 0, 0, 0, 1));
    // table row at 5 V is not advertised
    send_request(make_request(ACT_OTG_TMR, 75, 10, 0, 1));
    send_request(make_request(ACT_HV_ON, 50, 0, 1, 1));
    send_request(make_request(ACT_WLS_ON, 50, 0, 0, 1));
    send_request(make_request(ACT_HV_ON, 50, 0, 0, 1));
    send_request(make_request(ACT_WLS_OFF, 50, 0, 0, 1));
    send_request(make_request(ACT_HV_ON, 50, 0, 0, 0));
    send_request(make_request(ACT_HV_ON, 50, 0, 0, 1));
    send_request(make_request(ACT_HV_ON, 50, 0, 0, 1));
    send_request(make_request(ACT_MON_TMR, 55, 20, 0, 1));
    send_request(make_request(ACT_MON_TMR, 60, 45, 0, 1));
    send_request(make_request(ACT_MON_TMR, 60, 46, 0, 1));
    // no row met on the monitor timer gives 0/0
    send_request(make_request(ACT_MON_TMR, 5, 0, 0, 1));
    // otg on from high voltage keeps the monitor timer armed
    send_request(make_request(ACT_OTG_ON, 0, 0, 0, 1));
    send_request(make_request(ACT_MON_TMR, 100, 0, 0, 1));
    send_request(make_request(ACT_OTG_TMR, 100, 0, 1, 1));
    send_request(make_request(ACT_HV_ON, 0, 0, 0, 1));
    send_request(make_request(ACT_WLS_ON, 0, 0, 0, 0));
    send_request(make_request(ACT_WLS_OFF, 0, 0, 0, 1));
    send_request(make_request(ACT_HV_ON, 0, 0, 0, 1));
    send_request(make_request(ACT_OTG_OFF, 0, 0, 0, 1));
  endtask

  // one charge session: otg, optional delay timer, high voltage, monitoring, optional exit
  task automatic run_charge_session();
    request_t r;
    if (wls_on) send_request(random_request(ACT_WLS_OFF));
    send_request(random_request(ACT_OTG_ON));
    if ($urandom_range(0, 3) != 0) send_request(random_request(ACT_OTG_TMR));
    if ($urandom_range(0, 5) == 0) begin
      send_request(random_request(ACT_WLS_ON));
      send_request(random_request(ACT_WLS_OFF));
    end
    r = random_request(ACT_HV_ON);
    if ($urandom_range(0, 4) != 0) r.busy = 1'b0;
    send_request(r);
    repeat ($urandom_range(1, 6)) begin
      send_request(random_request(ACT_MON_TMR));
      if ($urandom_range(0, 9) == 0) send_request(random_request(ACT_OTG_ON));
    end
    case ($urandom_range(0, 4))
      0: send_request(random_request(ACT_HV_OFF));
      1: send_request(random_request(ACT_OTG_OFF));
      2: begin
        send_request(random_request(ACT_WLS_ON));
        send_request(random_request(ACT_WLS_OFF));
      end
      default: ;
    endcase
  endtask

  task automatic run_random_traffic(input int count, input bit allow_idle);
    int stop_at;
    int block_end;
    stop_at   = items_sent + count;
    block_end = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= block_end) begin
        idle_on   = allow_idle && ($urandom_range(0, 3) != 0);
        block_end = items_sent + 40;
      end
      if ($urandom_range(0, 4) != 0)
        run_charge_session();
      else
        repeat ($urandom_range(1, 4))
          send_request(random_request(action_t'($urandom_range(0, 7))));
    end
  endtask

  task automatic test_random_sessions();
    int per_phase;
    per_phase = (ITEM_TARGET - TAIL_ITEMS - items_sent) / 6;
    for (int phase = 0; phase < 6; phase++) begin
      load_random_config(phase);
      run_random_traffic(per_phase, 1'b1);
    end
  endtask

  task automatic test_quiet_tail();
    idle_on = 1'b0;
    load_random_config(2);
    run_random_traffic(TAIL_ITEMS, 1'b0);
  endtask

  initial begin
    reset_controller_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;
    test_mode_transitions();
    test_random_sessions();
    test_quiet_tail();
    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rcm_pkg.sv
rtl/rcm_cfg_regs.sv
rtl/rcm_cap_sel.sv
rtl/rcm_core.sv
rtl/reverse_charge_mode_controller_unit.sv
test/testbench.sv
